// File: hw/rtl/itbd_pkg.sv
// Shared types, constants and helper functions for the integer to base digits unit.
// Used by every module under hw/rtl; depends on nothing else.
package itbd_pkg;

    // Fixed field widths of the stream words
    localparam int IN_VALUE_BITS   = 64;
    localparam int RADIX_BITS      = 6;
    localparam int CHAR_BITS       = 7;
    localparam int S_TDATA_BITS    = 72;
    localparam int M_TDATA_BITS    = 8;

    // Sizing of the digit store and the front-to-back queue
    localparam int MAX_DIGITS      = 64;
    localparam int ADDR_BITS       = $clog2(MAX_DIGITS);
    localparam int COUNT_BITS      = ADDR_BITS + 1;
    localparam int QUEUE_DEPTH     = 2;
    localparam int DEF_VALUE_WIDTH = 64;

    // Radix limits and character codes
    localparam logic [RADIX_BITS-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 6'd36;
    localparam logic [RADIX_BITS-1:0] DEC_DIGITS = 6'd10;
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0]  CHAR_ALPHA = 7'h41;

    // Classified command that travels with each value through the queue
    typedef struct packed {
        logic                  bad;
        logic [RADIX_BITS-1:0] radix;
    } itbd_cmd_t;

    // One result word as held in the output register
    typedef struct packed {
        logic [CHAR_BITS-1:0] digit_char;
        logic                 last;
        logic                 bad_radix;
    } itbd_out_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_READ,
        ST_SEND
    } itbd_state_t;

    // Remainder code to ASCII: decimal digits first, then capital letters.
    function automatic logic [CHAR_BITS-1:0] code_to_ascii(input logic [RADIX_BITS-1:0] code);
        logic [CHAR_BITS-1:0] wide;
        wide = {1'b0, code};
        if (code < DEC_DIGITS)
        begin
            return CHAR_ZERO + wide;
        end
        return CHAR_ALPHA + wide - {1'b0, DEC_DIGITS};
    endfunction

endpackage

// File: hw/rtl/itbd_front.sv
// Front end: takes input words, masks the value and classifies the radix.
// Depends on itbd_pkg.
module itbd_front
    import itbd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [IN_VALUE_BITS-1:0] value,
    input  logic [RADIX_BITS-1:0]    radix,
    output logic                     push_valid,
    input  logic                     push_ready,
    output logic [VALUE_WIDTH-1:0]   push_value,
    output itbd_cmd_t                push_cmd
);

    // A word is taken whenever the queue has room.
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    // Bits above the configured width are ignored.
    assign push_value = value[VALUE_WIDTH-1:0];

    // Radix below two is an error; radix above the alphabet saturates.
    always_comb
    begin
        push_cmd.bad   = (radix < RADIX_MIN);
        push_cmd.radix = (radix > RADIX_MAX) ? RADIX_MAX : radix;
    end

endmodule

// File: hw/rtl/itbd_queue.sv
// Short first-in first-out queue that decouples the front end from the back end.
// Depends on itbd_pkg.
module itbd_queue
    import itbd_pkg::*;
#(
    parameter int WIDTH = DEF_VALUE_WIDTH + RADIX_BITS + 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_SLOT  = PW'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    // Handshake and occupancy
    assign push_ready = (cnt_reg != FULL_COUNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and count updates, wrapping at the last slot
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    // Occupancy never goes past the number of slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_COUNT)
        else $error("queue count exceeds depth");
`endif

endmodule

// File: hw/rtl/itbd_back.sv
// Back end: bit-serial division by the radix, digit store and most-significant-first emission.
// Depends on itbd_pkg.
module itbd_back
    import itbd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic [VALUE_WIDTH-1:0] q_value,
    input  itbd_cmd_t              q_cmd,
    output logic                   out_valid,
    input  logic                   out_ready,
    output itbd_out_t              out_word
);

    localparam int BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam logic [BW-1:0]         BIT_TOP   = BW'(VALUE_WIDTH - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = COUNT_BITS'(MAX_DIGITS - 1);

    itbd_state_t             state_reg, state_next;
    logic [VALUE_WIDTH-1:0]  quot_reg, quot_next;
    logic [RADIX_BITS-1:0]   rem_reg, rem_next;
    logic [RADIX_BITS-1:0]   radix_reg, radix_next;
    logic [BW-1:0]           bit_reg, bit_next;
    logic [COUNT_BITS-1:0]   n_reg, n_next;
    logic [ADDR_BITS-1:0]    ptr_reg, ptr_next;
    logic [RADIX_BITS-1:0]   rd_reg;
    logic                    out_valid_reg, out_valid_next;
    itbd_out_t               out_reg, out_next;
    logic                    load_out;
    logic                    mem_we;
    logic                    out_free;
    logic [RADIX_BITS:0]     trial;
    logic [RADIX_BITS:0]     diff;
    logic                    fits;
    logic [RADIX_BITS-1:0]   digit_mem [MAX_DIGITS];

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // One restoring division step: shift in the next dividend bit, try the subtract.
    assign trial = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, radix_reg};
    assign fits  = (trial >= {1'b0, radix_reg});

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        bit_next   = bit_reg;
        n_next     = n_reg;
        ptr_next   = ptr_reg;
        out_next   = out_reg;
        load_out   = 1'b0;
        mem_we     = 1'b0;
        q_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_ready = out_free;
                if (q_valid && out_free)
                begin
                    if (q_cmd.bad)
                    begin
                        load_out            = 1'b1;
                        out_next.digit_char = '0;
                        out_next.last       = 1'b1;
                        out_next.bad_radix  = 1'b1;
                    end
                    else
                    begin
                        quot_next  = q_value;
                        radix_next = q_cmd.radix;
                        rem_next   = '0;
                        bit_next   = BIT_TOP;
                        n_next     = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = fits ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
                quot_next = {quot_reg[VALUE_WIDTH-2:0], fits};
                bit_next  = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                mem_we = 1'b1;
                n_next = n_reg + 1'b1;
                if (quot_reg == '0 || n_reg == COUNT_TOP)
                begin
                    ptr_next   = n_reg[ADDR_BITS-1:0];
                    state_next = ST_READ;
                end
                else
                begin
                    rem_next   = '0;
                    bit_next   = BIT_TOP;
                    state_next = ST_DIV;
                end
            end
            ST_READ:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    load_out            = 1'b1;
                    out_next.digit_char = code_to_ascii(rd_reg);
                    out_next.last       = (ptr_reg == '0);
                    out_next.bad_radix  = 1'b0;
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register holds a word until the receiver takes it.
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        bit_reg   <= bit_next;
        ptr_reg   <= ptr_next;
        out_reg   <= out_next;
    end

    // Digit store, least significant digit at the lowest address
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[n_reg[ADDR_BITS-1:0]] <= rem_reg;
        end
        if (state_reg == ST_READ)
        begin
            rd_reg <= digit_mem[ptr_reg];
        end
    end

`ifndef SYNTHESIS
    // Division only ever runs with a valid, saturated radix.
    a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_STORE)
            |-> (radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX))
        else $error("division running with radix out of range");

    // A finished division leaves a remainder below the radix.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE) |-> (rem_reg < radix_reg))
        else $error("remainder not below radix");

    // Sending the least significant stored digit ends the run with a flagged word.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND && out_free && ptr_reg == '0)
            |=> (state_reg == ST_IDLE && out_valid_reg && out_reg.last))
        else $error("run did not end with last digit");
`endif

endmodule

// File: hw/rtl/integer_to_base_digits_unit.sv
// Top level of the integer to base digits unit: stream ports, front end, queue, back end.
// Depends on itbd_pkg, itbd_front, itbd_queue and itbd_back.
//
// Usage: each input word carries an unsigned value and a radix. The unit
// answers with the value's digits in that radix, most significant first, as
// ASCII ('0'-'9', then 'A'-'Z'), one digit per output word, with tlast on the
// final digit. A radix of 0 or 1 gives a single word with tuser set, tlast set
// and a zero character. A radix above 36 is treated as 36.
// Operation: each digit comes from the bit-serial divider, one dividend bit per
// cycle, most significant first, followed by a store into the digit memory; each
// digit is then read back from the digit memory and presented, in the ST_READ and
// ST_SEND states, where a stalled receiver holds the back end. No digit is presented
// until every digit of the value has been divided out and stored. An error word
// goes to the output register straight from the idle state, with no division. The
// back end takes the next word from the queue only once the last digit is
// sent; a two-entry queue lets the source hand over words while a conversion runs.
// Reset clears the queue, the sequencer and the output valid flag; no clearing
// pass is needed. When the receiver stalls, the current word holds in the
// output register and the back end waits; the queue fills and then tready drops.
module integer_to_base_digits_unit
    import itbd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,  // [63:0] value, [69:64] radix, rest zero
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [M_TDATA_BITS-1:0] m_axis_tdata,  // [6:0] digit_char, [7] zero
    output logic                    m_axis_tlast,
    output logic                    m_axis_tuser   // [0] bad_radix
);

    localparam int QW = VALUE_WIDTH + RADIX_BITS + 1;

    logic                   push_valid, push_ready;
    logic [VALUE_WIDTH-1:0] push_value;
    itbd_cmd_t              push_cmd;
    logic                   pop_valid, pop_ready;
    logic [QW-1:0]          pop_data;
    logic [VALUE_WIDTH-1:0] pop_value;
    itbd_cmd_t              pop_cmd;
    itbd_out_t              out_word;

    // Classification of incoming words
    itbd_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .value      (s_axis_tdata[IN_VALUE_BITS-1:0]),
        .radix      (s_axis_tdata[IN_VALUE_BITS+RADIX_BITS-1:IN_VALUE_BITS]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_value (push_value),
        .push_cmd   (push_cmd)
    );

    // Queue between front and back
    itbd_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_cmd, push_value}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_value = pop_data[VALUE_WIDTH-1:0];
    assign pop_cmd   = pop_data[QW-1:VALUE_WIDTH];

    // Conversion and emission
    itbd_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_value   (pop_value),
        .q_cmd     (pop_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    // Output word packing
    assign m_axis_tdata = {1'b0, out_word.digit_char};
    assign m_axis_tlast = out_word.last;
    assign m_axis_tuser = out_word.bad_radix;

endmodule

// File: test/itbd_checker.sv
// Stream checker for the integer to base digits unit: predicts the digit words of every
// accepted input word and compares them with the words that leave the unit.
// Depends on itbd_pkg for the field widths, radix limits and the result word layout.
module itbd_checker
    import itbd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,   // [63:0] value, [69:64] radix, rest zero
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [M_TDATA_BITS-1:0] m_axis_tdata,   // [6:0] digit_char, [7] zero
    input  logic                    m_axis_tlast,
    input  logic                    m_axis_tuser,   // [0] bad_radix
    output int                      mismatches,
    output int                      values_taken,
    output int                      digits_seen,
    output int                      bad_radix_seen,
    output int                      chars_owed
);

    // Digit words still to arrive, oldest first
    itbd_out_t owed_chars[$];
    itbd_out_t want;

    // ASCII glyph of one remainder: decimal digits, then capital letters.
    function automatic logic [CHAR_BITS-1:0] digit_glyph(input int unsigned code);
        if (code < DEC_DIGITS)
        begin
            return CHAR_BITS'(CHAR_ZERO + code);
        end
        return CHAR_BITS'(CHAR_ALPHA + code - DEC_DIGITS);
    endfunction

    // Works out every digit word that one input word causes and queues them.
    // The unit is built with the full 64-bit value width, so no bits are masked.
    task automatic expand_value(input logic [S_TDATA_BITS-1:0] word);
        logic [IN_VALUE_BITS-1:0] rest;
        int unsigned              base;
        int unsigned              codes[$];
        int                       k;
        itbd_out_t                entry;
        rest = word[IN_VALUE_BITS-1:0];
        base = {26'd0, word[IN_VALUE_BITS +: RADIX_BITS]};
        if (base < RADIX_MIN)
        begin
            // A radix of zero or one gives a single flagged word.
            entry.digit_char = '0;
            entry.last       = 1'b1;
            entry.bad_radix  = 1'b1;
            owed_chars.push_back(entry);
        end
        else
        begin
            if (base > RADIX_MAX)
            begin
                base = {26'd0, RADIX_MAX};
            end
            // Remainders come out least significant first; zero still gives one digit.
            do
            begin
                codes.push_back(32'(rest % base));
                rest = rest / base;
            end
            while (rest != 0 && codes.size() < MAX_DIGITS);
            for (k = codes.size() - 1; k >= 0; k--)
            begin
                entry.digit_char = digit_glyph(codes[k]);
                entry.last       = (k == 0);
                entry.bad_radix  = 1'b0;
                owed_chars.push_back(entry);
            end
        end
    endtask

    // Compare each delivered word with the oldest one owed, then take in new input words.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            owed_chars.delete();
            mismatches     = 0;
            values_taken   = 0;
            digits_seen    = 0;
            bad_radix_seen = 0;
            chars_owed     = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (m_axis_tuser)
                begin
                    bad_radix_seen++;
                end
                else
                begin
                    digits_seen++;
                end
                if (owed_chars.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: word with nothing owed: char %h last %b bad_radix %b",
                             $time, m_axis_tdata[CHAR_BITS-1:0], m_axis_tlast, m_axis_tuser);
                end
                else
                begin
                    want = owed_chars.pop_front();
                    if (m_axis_tdata[CHAR_BITS-1:0] !== want.digit_char)
                    begin
                        mismatches++;
                        $display("%0t: digit_char expected %h, got %h", $time,
                                 want.digit_char, m_axis_tdata[CHAR_BITS-1:0]);
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: last expected %b, got %b", $time,
                                 want.last, m_axis_tlast);
                    end
                    if (m_axis_tuser !== want.bad_radix)
                    begin
                        mismatches++;
                        $display("%0t: bad_radix expected %b, got %b", $time,
                                 want.bad_radix, m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expand_value(s_axis_tdata);
                values_taken++;
            end
            chars_owed = owed_chars.size();
        end
    end

endmodule

// File: test/tb.sv
// Top of the testbench for the integer to base digits unit: clock, reset, input words
// and receiver back-pressure, with the verdict at the end.
// Depends on itbd_pkg, integer_to_base_digits_unit and itbd_checker.
module tb;
    import itbd_pkg::*;

    localparam int HOLD_OFF_CYCLES = 900;
    localparam int TAIL_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 4000000;
    localparam int BURST_WORDS     = 8;
    localparam int RANDOM_WORDS    = 120;
    localparam int QUIET_WORDS     = 20;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata;   // [63:0] value, [69:64] radix, rest zero
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;   // [6:0] digit_char, [7] zero
    logic                    m_axis_tlast;
    logic                    m_axis_tuser;   // [0] bad_radix

    int mismatches;
    int values_taken;
    int digits_seen;
    int bad_radix_seen;
    int chars_owed;
    int values_sent   = 0;
    int hold_request  = 0;
    int cycle_count   = 0;
    bit calm          = 1'b0;

    integer_to_base_digits_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    itbd_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser),
        .mismatches     (mismatches),
        .values_taken   (values_taken),
        .digits_seen    (digits_seen),
        .bad_radix_seen (bad_radix_seen),
        .chars_owed     (chars_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offers one word, sometimes after a gap, and returns at the edge that accepts it.
    task automatic offer_word(input logic [IN_VALUE_BITS-1:0] value,
                              input logic [RADIX_BITS-1:0] radix);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, radix, value};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        values_sent++;
    endtask

    // Stops offering and waits until every owed digit word has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        wait (values_taken == values_sent && chars_owed == 0);
    endtask

    // Receiver: ready stretches, random stall bursts, and one long hold-off on request.
    initial
    begin
        int run;
        forever
        begin
            if (hold_request > 0)
            begin
                run = hold_request;
                hold_request = 0;
                repeat (run)
                begin
                    m_axis_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                run = $urandom_range(1, 17);
                repeat (run)
                begin
                    m_axis_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            else
            begin
                run = $urandom_range(1, 24);
                repeat (run)
                begin
                    m_axis_tready <= 1'b1;
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog on the cycle count.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        logic [IN_VALUE_BITS-1:0] value;
        logic [IN_VALUE_BITS-1:0] keep;
        logic [RADIX_BITS-1:0]    radix;
        int                       bits;
        int                       pick;
        int                       i;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: zero, full-scale values, digit boundaries, bad and oversized radices.
        offer_word(64'd0, 6'd10);
        offer_word(64'd0, 6'd2);
        offer_word({IN_VALUE_BITS{1'b1}}, 6'd2);
        offer_word({IN_VALUE_BITS{1'b1}}, 6'd16);
        offer_word({IN_VALUE_BITS{1'b1}}, RADIX_MAX);
        offer_word({IN_VALUE_BITS{1'b1}}, 6'd63);
        offer_word(64'd12345, 6'd10);
        offer_word(64'd9, 6'd10);
        offer_word(64'd10, 6'd11);
        offer_word(64'd35, RADIX_MAX);
        offer_word(64'd36, RADIX_MAX);
        offer_word(64'd1295, 6'd37);
        offer_word(64'h8000_0000_0000_0000, 6'd2);
        offer_word(64'h8000_0000_0000_0000, 6'd63);
        offer_word(64'hAAAA_AAAA_AAAA_AAAA, 6'd8);
        offer_word(64'h5555_5555_5555_5555, 6'd3);
        offer_word(64'd0, 6'd63);
        offer_word(64'd77, 6'd0);
        offer_word({IN_VALUE_BITS{1'b1}}, 6'd1);
        offer_word(64'd1, 6'd1);
        wait_drained();

        // Short values while the receiver holds off, so the queue fills and tready drops.
        hold_request = HOLD_OFF_CYCLES;
        for (i = 0; i < BURST_WORDS; i++)
        begin
            offer_word(IN_VALUE_BITS'($urandom_range(0, 1295)), RADIX_MAX);
        end

        // Random words: mostly narrow values, a share of full-width ones and bad radices.
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS - QUIET_WORDS)
            begin
                calm = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                bits = $urandom_range(1, 12);
            end
            else if (pick < 8)
            begin
                bits = $urandom_range(13, 32);
            end
            else
            begin
                bits = IN_VALUE_BITS;
            end
            value = {$urandom, $urandom};
            if (bits < IN_VALUE_BITS)
            begin
                keep  = (64'd1 << bits) - 64'd1;
                value = value & keep;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                radix = RADIX_BITS'($urandom_range(0, 1));
            end
            else
            begin
                radix = RADIX_BITS'($urandom_range(2, 63));
            end
            offer_word(value, radix);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d values into %0d digit words and %0d bad-radix words,",
                 values_taken, digits_seen, bad_radix_seen);
        $display("covering radices 0 to 63, full 64-bit values and a long receiver hold-off.");
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/itbd_pkg.sv
hw/rtl/itbd_front.sv
hw/rtl/itbd_queue.sv
hw/rtl/itbd_back.sv
hw/rtl/integer_to_base_digits_unit.sv
test/itbd_checker.sv
test/tb.sv
